// ===== rtl/hpt_pkg.sv =====
// hpt_pkg: shared types and constants of the homogeneous point transform.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package hpt_pkg;
   localparam int COORD_W   = 32;
   localparam int IDX_W     = 4;
   localparam int N_ENTRIES = 16;
   localparam int THR_W     = 17;
   localparam int DIV_BITS  = 32;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [IDX_W-1:0]          index_type;
   typedef logic [THR_W-1:0]          thr_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_XFORM = 1'b1
   } mode_type;

   localparam thr_type THR_RESET = thr_type'(1);
endpackage
`default_nettype wire

// ===== rtl/hpt_req_if.sv =====
// hpt_req_if: input channel, one beat is a matrix load or a point.
// Depends on hpt_pkg.
`default_nettype none
interface hpt_req_if;
   import hpt_pkg::*;
   logic      valid;
   logic      ready;
   mode_type  mode;
   index_type entry_index;
   coord_type entry_value;
   coord_type in_x;
   coord_type in_y;
   coord_type in_z;
   modport source (output valid, mode, entry_index, entry_value, in_x, in_y, in_z,
                   input ready);
   modport sink (input valid, mode, entry_index, entry_value, in_x, in_y, in_z,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/hpt_rsp_if.sv =====
// hpt_rsp_if: result channel, one beat per transformed point.
// Depends on hpt_pkg.
`default_nettype none
interface hpt_rsp_if;
   import hpt_pkg::*;
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      w_near_zero;
   logic      saturated;
   modport source (output valid, out_x, out_y, out_z, w_near_zero, saturated,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, w_near_zero, saturated,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/homogeneous_point_transform_top.sv =====
// homogeneous_point_transform_top: 4x4 matrix transform with perspective divide.
// Depends on hpt_pkg, hpt_req_if and hpt_rsp_if.
`default_nettype none
// One beat is accepted every cycle unless the pipe is stalled; a point's result passes
// through the products, the sums, the weight check, the pipelined restoring divider
// (DIV_STEPS quotient bits per stage) and the output register. A load beat writes
// the matrix at acceptance, so later points see it; it yields no result. The whole
// pipe stalls only while a result waits on the output. csr_we writes zero_threshold;
// the user must write it only while idle, as the block does not enforce it.
module homogeneous_point_transform_top #(
   parameter int FRAC_BITS = 16,
   parameter int DIV_STEPS = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   hpt_req_if.sink              req_ch,
   hpt_rsp_if.source            rsp_ch,
   input  wire logic            csr_we,
   input  wire hpt_pkg::thr_type csr_wdata
);
   import hpt_pkg::*;

   localparam int SH_W  = 2 * COORD_W - FRAC_BITS;
   localparam int ACC_W = SH_W + 2;
   localparam int N_W   = ACC_W + FRAC_BITS;
   localparam int R_W   = ACC_W + 1;
   localparam int NDS   = DIV_BITS / DIV_STEPS;

   logic en;
   logic rsp_valid_ff;
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // matrix and threshold
   coord_type matrix_ff [N_ENTRIES];
   thr_type   thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N_ENTRIES; k++) begin
            matrix_ff[k] <= (k % 5 == 0) ? coord_type'(1) <<< FRAC_BITS : '0;
         end
      end else if (en && req_ch.valid && req_ch.mode == MODE_LOAD) begin
         matrix_ff[req_ch.entry_index] <= req_ch.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // stage 1: products
   logic                          v1_ff;
   logic signed [2*COORD_W-1:0]   p1_ff [4][3];
   logic signed [2*COORD_W-1:0]   p1_in [4][3];
   coord_type                     t1_ff [4];
   coord_type                     pt    [3];

   assign pt[0] = req_ch.in_x;
   assign pt[1] = req_ch.in_y;
   assign pt[2] = req_ch.in_z;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 3; i++) begin
            p1_in[c][i] = matrix_ff[i*4+c] * pt[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid && req_ch.mode == MODE_XFORM;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         for (int c = 0; c < 4; c++) begin
            t1_ff[c] <= matrix_ff[12+c];
         end
      end
   end

   // stage 2: floor shift and sum
   logic                     v2_ff;
   logic signed [ACC_W-1:0]  acc2_ff [4];
   logic signed [ACC_W-1:0]  acc2_in [4];

   always_comb begin
      logic signed [2*COORD_W-1:0] sh;
      for (int c = 0; c < 4; c++) begin
         acc2_in[c] = ACC_W'(t1_ff[c]);
         for (int i = 0; i < 3; i++) begin
            sh         = p1_ff[c][i] >>> FRAC_BITS;
            acc2_in[c] = acc2_in[c] + $signed(sh[ACC_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc2_ff <= acc2_in;
      end
   end

   // stage 3: weight check, magnitudes, divider setup; divider stages follow
   logic                 v_ff    [NDS+1];
   logic [ACC_W-1:0]     b_ff    [NDS+1];
   logic                 near_ff [NDS+1];
   logic [R_W-1:0]       rem_ff  [NDS+1][3];
   logic [DIV_BITS-1:0]  nl_ff   [NDS+1][3];
   logic [DIV_BITS-1:0]  q_ff    [NDS+1][3];
   logic                 neg_ff  [NDS+1][3];
   logic                 ovf_ff  [NDS+1][3];
   coord_type            satv_ff [NDS+1][3];
   logic                 satc_ff [NDS+1][3];

   logic [ACC_W-1:0]     wmag_in;
   logic                 near_in;
   logic [R_W-1:0]       rem_in  [3];
   logic [DIV_BITS-1:0]  nl_in   [3];
   logic                 neg_in  [3];
   logic                 ovf_in  [3];
   coord_type            satv_in [3];
   logic                 satc_in [3];

   always_comb begin
      logic [ACC_W-1:0] amag;
      logic [N_W-1:0]   num;
      wmag_in = acc2_ff[3][ACC_W-1] ? ACC_W'(-acc2_ff[3]) : ACC_W'(acc2_ff[3]);
      near_in = (acc2_ff[3] == '0) || (wmag_in < ACC_W'(thr_ff));
      for (int c = 0; c < 3; c++) begin
         amag       = acc2_ff[c][ACC_W-1] ? ACC_W'(-acc2_ff[c]) : ACC_W'(acc2_ff[c]);
         num        = {amag, {FRAC_BITS{1'b0}}};
         neg_in[c]  = acc2_ff[c][ACC_W-1] ^ acc2_ff[3][ACC_W-1];
         ovf_in[c]  = ACC_W'(num[N_W-1:DIV_BITS]) >= wmag_in;
         rem_in[c]  = R_W'(num[N_W-1:DIV_BITS]);
         nl_in[c]   = num[DIV_BITS-1:0];
         satc_in[c] = 1'b0;
         if (acc2_ff[c] > ACC_W'(signed'(32'sh7fffffff))) begin
            satv_in[c] = 32'sh7fffffff;
            satc_in[c] = 1'b1;
         end else if (acc2_ff[c] < ACC_W'(signed'(32'sh80000000))) begin
            satv_in[c] = 32'sh80000000;
            satc_in[c] = 1'b1;
         end else begin
            satv_in[c] = acc2_ff[c][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff[0]    <= wmag_in;
         near_ff[0] <= near_in;
         for (int c = 0; c < 3; c++) begin
            rem_ff[0][c]  <= rem_in[c];
            nl_ff[0][c]   <= nl_in[c];
            q_ff[0][c]    <= '0;
            neg_ff[0][c]  <= neg_in[c];
            ovf_ff[0][c]  <= ovf_in[c];
            satv_ff[0][c] <= satv_in[c];
            satc_ff[0][c] <= satc_in[c];
         end
      end
   end

   for (genvar s = 0; s < NDS; s++) begin : g_div
      logic [R_W-1:0]      rem_nx [3];
      logic [DIV_BITS-1:0] nl_nx  [3];
      logic [DIV_BITS-1:0] q_nx   [3];

      always_comb begin
         logic [R_W-1:0]      r;
         logic [DIV_BITS-1:0] nl;
         logic [DIV_BITS-1:0] q;
         for (int c = 0; c < 3; c++) begin
            r  = rem_ff[s][c];
            nl = nl_ff[s][c];
            q  = q_ff[s][c];
            for (int k = 0; k < DIV_STEPS; k++) begin
               r  = {r[R_W-2:0], nl[DIV_BITS-1]};
               nl = {nl[DIV_BITS-2:0], 1'b0};
               if (r >= {1'b0, b_ff[s]}) begin
                  r = r - {1'b0, b_ff[s]};
                  q = {q[DIV_BITS-2:0], 1'b1};
               end else begin
                  q = {q[DIV_BITS-2:0], 1'b0};
               end
            end
            rem_nx[c] = r;
            nl_nx[c]  = nl;
            q_nx[c]   = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            b_ff[s+1]    <= b_ff[s];
            near_ff[s+1] <= near_ff[s];
            rem_ff[s+1]  <= rem_nx;
            nl_ff[s+1]   <= nl_nx;
            q_ff[s+1]    <= q_nx;
            neg_ff[s+1]  <= neg_ff[s];
            ovf_ff[s+1]  <= ovf_ff[s];
            satv_ff[s+1] <= satv_ff[s];
            satc_ff[s+1] <= satc_ff[s];
         end
      end
   end

   // output: limit, sign, select
   coord_type res_in [3];
   logic      clip_in;

   always_comb begin
      logic [DIV_BITS-1:0] limit;
      logic [DIV_BITS-1:0] total;
      clip_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         limit = neg_ff[NDS][c] ? 32'h80000000 : 32'h7fffffff;
         total = q_ff[NDS][c];
         if (near_ff[NDS]) begin
            res_in[c] = satv_ff[NDS][c];
            clip_in   = clip_in | satc_ff[NDS][c];
         end else begin
            if (ovf_ff[NDS][c] || total > limit) begin
               total   = limit;
               clip_in = 1'b1;
            end
            res_in[c] = neg_ff[NDS][c] ? coord_type'(-total) : coord_type'(total);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[NDS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ch.out_x       <= res_in[0];
         rsp_ch.out_y       <= res_in[1];
         rsp_ch.out_z       <= res_in[2];
         rsp_ch.w_near_zero <= near_ff[NDS];
         rsp_ch.saturated   <= clip_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

   // checks
   a_load_no_beat: assert property (@(posedge clock) disable iff (reset)
      en && req_ch.valid && req_ch.mode == MODE_LOAD |=> !v1_ff)
      else $error("load beat entered the pipe");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v1_ff) && $stable(v_ff[0]) && $stable(v_ff[NDS]))
      else $error("pipe moved during stall");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !v1_ff)
      else $error("valid survived reset");

endmodule
`default_nettype wire
